### rtl/fcss_pkg.sv
// Package for the firmware chunk stream sequencer: parse phases, event kinds,
// the result record type and the fixed constants of the record format.
// Used by firmware_chunk_stream_sequencer_top; depends on nothing.
`default_nettype none

package fcss_pkg;

	// Largest bus write is one register byte plus this many less one payload bytes.
	localparam int unsigned WRITE_BUFFER_BYTES = 64;
	localparam int unsigned BIW_W = $clog2(WRITE_BUFFER_BYTES);

	// Results one input byte can cause at most.
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned RES_IDX_W = $clog2(MAX_RESULTS + 1);

	// Field widths.
	localparam int unsigned SIZE_W = 24;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CODE_W = 16;
	localparam int unsigned VALUE_W = 15;

	// Record codes.
	localparam logic [CODE_W-1:0] CODE_TUNER_RESET = 16'h0000;
	localparam logic [CODE_W-1:0] CODE_CLOCK_RESET = 16'hFF00;
	localparam logic [CODE_W-1:0] CODE_EXIT        = 16'hFFFF;
	localparam int unsigned       CODE_DELAY_BIT   = 15;

	typedef enum logic [1:0] {
		PH_CODE_HI,
		PH_CODE_LO,
		PH_REG,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [2:0] {
		EV_BUS         = 3'd0,
		EV_TUNER_RESET = 3'd1,
		EV_CLOCK_RESET = 3'd2,
		EV_DELAY       = 3'd3,
		EV_EXIT        = 3'd4,
		EV_IMAGE_END   = 3'd5,
		EV_BAD_CODE    = 3'd6,
		EV_OVERRUN     = 3'd7
	} event_kind_t;

	typedef struct packed {
		event_kind_t        kind;
		logic [VALUE_W-1:0] value;
		logic               wend;
	} result_t;

endpackage

`default_nettype wire

### rtl/firmware_chunk_stream_sequencer_top.sv
// Top level of the firmware chunk stream sequencer: input register, record
// parser and a result register that hands out up to three results per byte.
// Depends on fcss_pkg.
//
//   Channel   Handshake             Payload
//   --------  --------------------  ------------------------------------------
//   input     in_valid / in_stall   image_byte, image_start
//   output    out_valid / out_stall event_kind, event_value, write_end,
//                                   last_result
//   config    cfg_write             cfg_data (image size, 24 bits)
//
// A byte waits in the input register and is parsed on its way into the result
// register, from which its first result goes onto the output.
// The output port delivers one result per cycle while out_stall is low, and a
// byte holds the result register until all the results it causes (one for
// most bytes, at most three) are taken; bytes causing no result pass at one
// per cycle while the result register is free. arst_n clears the parse state
// and the image size. A stalled output holds the result register and the
// input register fills behind it before in_stall rises.
`default_nettype none

module firmware_chunk_stream_sequencer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration
	input  wire logic                             cfg_write,
	input  wire logic [fcss_pkg::SIZE_W-1:0]      cfg_data,
	// Input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [fcss_pkg::BYTE_W-1:0]      image_byte,
	input  wire logic                             image_start,
	// Output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [2:0]                            event_kind,
	output logic [fcss_pkg::VALUE_W-1:0]          event_value,
	output logic                                  write_end,
	output logic                                  last_result
);

	localparam int unsigned SW  = fcss_pkg::SIZE_W;
	localparam int unsigned BW  = fcss_pkg::BYTE_W;
	localparam int unsigned CW  = fcss_pkg::CODE_W;
	localparam int unsigned VW  = fcss_pkg::VALUE_W;
	localparam int unsigned IW  = fcss_pkg::BIW_W;
	localparam int unsigned RW  = fcss_pkg::RES_IDX_W;
	localparam int unsigned NR  = fcss_pkg::MAX_RESULTS;

	// Configuration register.
	logic [SW-1:0] image_size_q;

	// Input register.
	logic          valid_s1;
	logic [BW-1:0] byte_s1;
	logic          start_s1;

	// Parse state.
	fcss_pkg::phase_t ph_q;
	logic [SW-1:0]    pos_q;
	logic [BW-1:0]    hi_q;
	logic [CW-1:0]    rem_q;
	logic [BW-1:0]    reg_q;
	logic [IW-1:0]    biw_q;
	logic             stop_q;

	// Result register.
	logic                valid_s2;
	fcss_pkg::result_t   res_s2 [NR];
	logic [RW-1:0]       cnt_s2;
	logic [RW-1:0]       idx_q;

	// Parse state as seen by the byte in the input register.
	fcss_pkg::phase_t ph_e;
	logic [SW-1:0]    pos_e;
	logic [BW-1:0]    hi_e;
	logic [CW-1:0]    rem_e;
	logic [BW-1:0]    reg_e;
	logic [IW-1:0]    biw_e;
	logic             stop_e;

	// Next parse state.
	fcss_pkg::phase_t ph_n;
	logic [SW-1:0]    pos_n;
	logic [BW-1:0]    hi_n;
	logic [CW-1:0]    rem_n;
	logic [BW-1:0]    reg_n;
	logic [IW-1:0]    biw_n;
	logic             stop_n;

	// Shared decode terms.
	logic [SW-1:0] pos_inc;
	logic [CW-1:0] code;
	logic          few_now;
	logic          few_next;
	logic          overrun;
	logic          is_fatal;
	logic          is_event;
	logic [CW-1:0] rem_dec;
	logic [IW-1:0] biw_inc;
	logic          wend;

	// Results of the byte being parsed.
	fcss_pkg::result_t res_c [NR];
	logic [RW-1:0]     cnt_c;

	// Handshake terms.
	logic s2_done;
	logic s2_free;
	logic take_s1;
	logic load_s1;

	// Handshake between the input register and the result register.
	assign s2_done  = valid_s2 && !out_stall && (idx_q == cnt_s2 - RW'(1));
	assign s2_free  = !valid_s2 || s2_done;
	assign take_s1  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign load_s1  = in_valid && !in_stall;

	// Output fields come from the result selected by the index.
	assign out_valid   = valid_s2;
	assign event_kind  = res_s2[idx_q].kind;
	assign event_value = res_s2[idx_q].value;
	assign write_end   = res_s2[idx_q].wend;
	assign last_result = (idx_q == cnt_s2 - RW'(1));

	// A start flag clears the parse state before the byte is taken.
	always_comb begin
		if (start_s1) begin
			ph_e   = fcss_pkg::PH_CODE_HI;
			pos_e  = '0;
			hi_e   = '0;
			rem_e  = '0;
			reg_e  = '0;
			biw_e  = '0;
			stop_e = 1'b0;
		end else begin
			ph_e   = ph_q;
			pos_e  = pos_q;
			hi_e   = hi_q;
			rem_e  = rem_q;
			reg_e  = reg_q;
			biw_e  = biw_q;
			stop_e = stop_q;
		end
	end

	// Position checks against the image size and payload counting.
	assign pos_inc  = pos_e + SW'(1);
	assign code     = {hi_e, byte_s1};
	assign few_now  = ({1'b0, pos_e} + (SW+1)'(2)) > {1'b0, image_size_q};
	assign few_next = ({1'b0, pos_inc} + (SW+1)'(2)) > {1'b0, image_size_q};
	assign overrun  = ({1'b0, pos_inc} + (SW+1)'(code)) > {1'b0, image_size_q};
	assign is_fatal = (code > fcss_pkg::CODE_CLOCK_RESET);
	assign is_event = (code == fcss_pkg::CODE_TUNER_RESET) || code[fcss_pkg::CODE_DELAY_BIT];
	assign rem_dec  = (rem_e != '0) ? rem_e - CW'(1) : rem_e;
	assign biw_inc  = biw_e + IW'(1);
	assign wend     = (rem_dec == '0) || (biw_inc >= IW'(fcss_pkg::WRITE_BUFFER_BYTES - 1));

	// Next parse state.
	always_comb begin
		ph_n   = ph_e;
		pos_n  = pos_e;
		hi_n   = hi_e;
		rem_n  = rem_e;
		reg_n  = reg_e;
		biw_n  = biw_e;
		stop_n = stop_e;
		if (!stop_e) begin
			if (ph_e == fcss_pkg::PH_CODE_HI && few_now) begin
				stop_n = 1'b1;
			end else begin
				pos_n = pos_inc;
				case (ph_e)
					fcss_pkg::PH_CODE_HI: begin
						hi_n = byte_s1;
						ph_n = fcss_pkg::PH_CODE_LO;
					end
					fcss_pkg::PH_CODE_LO: begin
						ph_n = fcss_pkg::PH_CODE_HI;
						if (is_fatal) begin
							stop_n = 1'b1;
						end else if (is_event) begin
							stop_n = few_next;
						end else if (overrun) begin
							stop_n = 1'b1;
						end else begin
							rem_n = code - CW'(1);
							biw_n = '0;
							ph_n  = fcss_pkg::PH_REG;
						end
					end
					fcss_pkg::PH_REG: begin
						reg_n = byte_s1;
						if (rem_e == '0) begin
							ph_n   = fcss_pkg::PH_CODE_HI;
							stop_n = few_next;
						end else begin
							ph_n = fcss_pkg::PH_PAYLOAD;
						end
					end
					fcss_pkg::PH_PAYLOAD: begin
						rem_n = rem_dec;
						biw_n = wend ? '0 : biw_inc;
						if (rem_dec == '0) begin
							ph_n   = fcss_pkg::PH_CODE_HI;
							stop_n = few_next;
						end
					end
					default: begin
						ph_n = fcss_pkg::PH_CODE_HI;
					end
				endcase
			end
		end
	end

	// Results of the byte, collected in order.
	always_comb begin
		for (int i = 0; i < NR; i++) begin
			res_c[i] = '{kind: fcss_pkg::EV_BUS, value: '0, wend: 1'b0};
		end
		cnt_c = '0;
		if (!stop_e) begin
			if (ph_e == fcss_pkg::PH_CODE_HI && few_now) begin
				res_c[0].kind = fcss_pkg::EV_IMAGE_END;
				cnt_c         = RW'(1);
			end else begin
				case (ph_e)
					fcss_pkg::PH_CODE_LO: begin
						if (code == fcss_pkg::CODE_TUNER_RESET) begin
							res_c[0].kind = fcss_pkg::EV_TUNER_RESET;
						end else if (code == fcss_pkg::CODE_CLOCK_RESET) begin
							res_c[0].kind = fcss_pkg::EV_CLOCK_RESET;
						end else if (code == fcss_pkg::CODE_EXIT) begin
							res_c[0].kind = fcss_pkg::EV_EXIT;
						end else if (is_fatal) begin
							res_c[0].kind = fcss_pkg::EV_BAD_CODE;
						end else if (code[fcss_pkg::CODE_DELAY_BIT]) begin
							res_c[0].kind  = fcss_pkg::EV_DELAY;
							res_c[0].value = code[VW-1:0];
						end else if (overrun) begin
							res_c[0].kind = fcss_pkg::EV_OVERRUN;
						end
						if (is_fatal || is_event || overrun) begin
							cnt_c = RW'(1);
						end
						// Reset and delay records may close the image.
						if (!is_fatal && is_event && few_next) begin
							res_c[1].kind = fcss_pkg::EV_IMAGE_END;
							cnt_c         = RW'(2);
						end
					end
					fcss_pkg::PH_REG: begin
						if (rem_e == '0 && few_next) begin
							res_c[0].kind = fcss_pkg::EV_IMAGE_END;
							cnt_c         = RW'(1);
						end
					end
					fcss_pkg::PH_PAYLOAD: begin
						// A new write opens with the register byte.
						if (biw_e == '0) begin
							res_c[0].value = VW'(reg_e);
							res_c[1].value = VW'(byte_s1);
							res_c[1].wend  = wend;
							cnt_c          = RW'(2);
						end else begin
							res_c[0].value = VW'(byte_s1);
							res_c[0].wend  = wend;
							cnt_c          = RW'(1);
						end
						if (rem_dec == '0 && few_next) begin
							res_c[cnt_c].kind = fcss_pkg::EV_IMAGE_END;
							cnt_c             = cnt_c + RW'(1);
						end
					end
					default: begin
						cnt_c = '0;
					end
				endcase
			end
		end
	end

	// Image size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_write) begin
			image_size_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= image_byte;
			start_s1 <= image_start;
		end
	end

	// Parse state advances as a byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= fcss_pkg::PH_CODE_HI;
			pos_q  <= '0;
			hi_q   <= '0;
			rem_q  <= '0;
			reg_q  <= '0;
			biw_q  <= '0;
			stop_q <= 1'b0;
		end else if (take_s1) begin
			ph_q   <= ph_n;
			pos_q  <= pos_n;
			hi_q   <= hi_n;
			rem_q  <= rem_n;
			reg_q  <= reg_n;
			biw_q  <= biw_n;
			stop_q <= stop_n;
		end
	end

	// Result register control and the index of the result on the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= '0;
			idx_q    <= '0;
		end else if (take_s1) begin
			valid_s2 <= (cnt_c != '0);
			cnt_s2   <= cnt_c;
			idx_q    <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && !out_stall) begin
			idx_q <= idx_q + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int i = 0; i < NR; i++) begin
				res_s2[i] <= res_c[i];
			end
		end
	end

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for firmware_chunk_stream_sequencer_top: firmware images are
// streamed byte by byte and every result is compared with a model of the record parser.
// Depends on fcss_pkg and the top-level RTL; nothing else is read or needed.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcss_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 16;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 440;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [BIW_W-1:0] WRITE_MAX = BIW_W'(WRITE_BUFFER_BYTES - 1);

	typedef struct packed {
		event_kind_t        kind;
		logic [VALUE_W-1:0] value;
		logic               wend;
		logic               last;
	} fw_event_t;

	// Directed rows: a size write, a byte checked by the parser model, a byte with one
	// typed result, or a byte that must cause nothing.
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PRED,
		ROW_ONE,
		ROW_NONE
	} row_kind_t;

	typedef struct packed {
		row_kind_t          what;
		logic               start;
		logic [BYTE_W-1:0]  data;
		logic [SIZE_W-1:0]  cfg_size;
		event_kind_t        ev;
		logic [VALUE_W-1:0] value;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic [SIZE_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   image_byte = '0;
	logic                image_start = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          event_kind;
	logic [VALUE_W-1:0]  event_value;
	logic                write_end;
	logic                last_result;

	firmware_chunk_stream_sequencer_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.image_byte  (image_byte),
		.image_start (image_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_value (event_value),
		.write_end   (write_end),
		.last_result (last_result)
	);

	always #HALF_PERIOD clk = ~clk;

	// Parser model state and the results of the byte taken last.
	phase_t              parse_ph;
	logic [SIZE_W-1:0]   parse_pos;
	logic [BYTE_W-1:0]   code_hi;
	logic [CODE_W-1:0]   chunk_left;
	logic [BYTE_W-1:0]   reg_byte;
	logic [BIW_W-1:0]    write_count;
	logic                parser_halted;
	logic [SIZE_W-1:0]   size_now;
	fw_event_t           step_out [MAX_RESULTS];
	int                  step_n;

	fw_event_t           events_due [$];
	dir_row_t            dir_rows [$];
	logic [BYTE_W-1:0]   img_bytes [$];

	int fail_count = 0;
	int results_checked = 0;
	int bytes_offered = 0;
	int live_items = 0;
	int size_writes = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_len = 0;
	int holds_wanted = 0;
	int holds_done = 0;
	int hold_count = 0;
	int rx_mode = 0;
	int rx_left = 0;

	function automatic void clear_parser();
		parse_ph = PH_CODE_HI;
		parse_pos = '0;
		code_hi = '0;
		chunk_left = '0;
		reg_byte = '0;
		write_count = '0;
		parser_halted = 1'b0;
	endfunction

	function automatic void emit(event_kind_t k, logic [VALUE_W-1:0] v, logic we);
		if (step_n < MAX_RESULTS) begin
			step_out[step_n].kind = k;
			step_out[step_n].value = v;
			step_out[step_n].wend = we;
			step_out[step_n].last = 1'b0;
			step_n++;
		end
	endfunction

	function automatic logic too_few_left();
		return ({1'b0, parse_pos} + 25'd2) > {1'b0, size_now};
	endfunction

	// At a record boundary the image ends once fewer than two bytes remain.
	function automatic void close_record();
		parse_ph = PH_CODE_HI;
		if (too_few_left()) begin
			emit(EV_IMAGE_END, '0, 1'b0);
			parser_halted = 1'b1;
		end
	endfunction

	// Works out the results one accepted byte causes and advances the model.
	function automatic void parse_image_byte(logic s, logic [BYTE_W-1:0] b);
		logic [CODE_W-1:0] code;
		logic wend;
		step_n = 0;
		if (s)
			clear_parser();
		if (parser_halted)
			return;
		live_items++;
		if (parse_ph == PH_CODE_HI && too_few_left()) begin
			emit(EV_IMAGE_END, '0, 1'b0);
			parser_halted = 1'b1;
		end else begin
			parse_pos = parse_pos + 1'b1;
			case (parse_ph)
				PH_CODE_HI: begin
					code_hi = b;
					parse_ph = PH_CODE_LO;
				end
				PH_CODE_LO: begin
					code = {code_hi, b};
					if (code == CODE_TUNER_RESET) begin
						emit(EV_TUNER_RESET, '0, 1'b0);
						close_record();
					end else if (code == CODE_CLOCK_RESET) begin
						emit(EV_CLOCK_RESET, '0, 1'b0);
						close_record();
					end else if (code == CODE_EXIT) begin
						emit(EV_EXIT, '0, 1'b0);
						parser_halted = 1'b1;
					end else if (code > CODE_CLOCK_RESET) begin
						emit(EV_BAD_CODE, '0, 1'b0);
						parser_halted = 1'b1;
					end else if (code[CODE_DELAY_BIT]) begin
						emit(EV_DELAY, code[VALUE_W-1:0], 1'b0);
						close_record();
					end else if (({1'b0, parse_pos} + {9'd0, code}) > {1'b0, size_now}) begin
						emit(EV_OVERRUN, '0, 1'b0);
						parser_halted = 1'b1;
					end else begin
						chunk_left = code - 16'd1;
						write_count = '0;
						parse_ph = PH_REG;
					end
				end
				PH_REG: begin
					reg_byte = b;
					if (chunk_left == '0)
						close_record();
					else
						parse_ph = PH_PAYLOAD;
				end
				default: begin
					// Every bus write is led by the register byte.
					if (write_count == '0)
						emit(EV_BUS, {7'd0, reg_byte}, 1'b0);
					write_count = write_count + 1'b1;
					if (chunk_left != '0)
						chunk_left = chunk_left - 16'd1;
					wend = (chunk_left == '0) || (write_count >= WRITE_MAX);
					emit(EV_BUS, {7'd0, b}, wend);
					if (wend)
						write_count = '0;
					if (chunk_left == '0)
						close_record();
				end
			endcase
		end
		if (step_n > 0)
			step_out[step_n - 1].last = 1'b1;
	endfunction

	function automatic void queue_predicted();
		for (int i = 0; i < step_n; i++)
			events_due.push_back(step_out[i]);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[BYTE_W-1:0];
	endfunction

	function automatic void push_code(logic [31:0] c);
		img_bytes.push_back(c[15:8]);
		img_bytes.push_back(c[7:0]);
	endfunction

	function automatic void add_row(row_kind_t what, logic start, logic [BYTE_W-1:0] data,
			logic [SIZE_W-1:0] cfg_size, event_kind_t ev, logic [VALUE_W-1:0] value);
		dir_row_t r;
		r.what = what;
		r.start = start;
		r.data = data;
		r.cfg_size = cfg_size;
		r.ev = ev;
		r.value = value;
		dir_rows.push_back(r);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Offer one request on the input channel, in bursts with random gaps, and run the
	// parser model at the edge that takes it.
	task automatic offer(logic s, logic [BYTE_W-1:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_len > 0) begin
				in_valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		image_byte <= b;
		image_start <= s;
		bytes_offered++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_image_byte(s, b);
	endtask

	// Stop offering and wait until every expected result has arrived and the pipeline is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [31:0] v);
		cfg_write <= 1'b1;
		cfg_data <= v[SIZE_W-1:0];
		@(posedge clk);
		size_now = v[SIZE_W-1:0];
		size_writes++;
		cfg_write <= 1'b0;
	endtask

	// Random image: mostly well-formed records with random content, some ending on a bad
	// code, an oversized chunk or an exit marker, and some plain noise.
	task automatic build_image(output int unsigned sz, output bit noisy);
		int unsigned flavour, pick, len;
		img_bytes.delete();
		flavour = $urandom_range(0, 9);
		noisy = (flavour == 0);
		if (noisy) begin
			len = $urandom_range(2, 14);
			repeat (len) img_bytes.push_back(rand_byte());
			sz = $urandom_range(0, 24);
		end else begin
			repeat ($urandom_range(1, 5)) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					push_code(32'h0000);
				end else if (pick == 1) begin
					push_code(32'hFF00);
				end else if (pick <= 3) begin
					push_code(32'h8000 + $urandom_range(0, 32'h7EFF));
				end else begin
					// Now and then a long chunk, which can need more than one bus write.
					len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 130) :
						$urandom_range(1, 10);
					push_code(len);
					repeat (len) img_bytes.push_back(rand_byte());
				end
			end
			sz = img_bytes.size() + $urandom_range(0, 1);
			if (flavour == 1) begin
				push_code(32'hFF01 + $urandom_range(0, 253));
				sz = img_bytes.size() + 4;
			end else if (flavour == 2) begin
				push_code($urandom_range(1, 32'h7FFF));
				sz = img_bytes.size() + $urandom_range(0, 2);
			end else if (flavour == 3) begin
				push_code(32'hFFFF);
				sz = ($urandom_range(0, 1) == 0) ? 32'hFFFFFF : img_bytes.size();
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) img_bytes.push_back(rand_byte());
		end
	endtask

	// Receiver stall pattern: changing modes, plus long hold-offs on request.
	always @(posedge clk) begin : stall_pattern
		if (holds_done < holds_wanted) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count == LONG_HOLD) begin
				hold_count = 0;
				holds_done++;
			end
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (rx_left % 3 == 0);
			endcase
		end
	end

	// Compare every accepted result with the oldest expected one.
	always @(posedge clk) begin : result_check
		fw_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (events_due.size() == 0) begin
				$error("unexpected result: event_kind %0d event_value %0d", event_kind,
					event_value);
				fail_count++;
			end else begin
				want = events_due.pop_front();
				check_field("event_kind", int'(want.kind), int'(event_kind));
				check_field("event_value", int'(want.value), int'(event_value));
				check_field("write_end", int'(want.wend), int'(write_end));
				check_field("last_result", int'(want.last), int'(last_result));
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		fw_event_t typed;
		int unsigned sz, new_sz, split, image_count, random_from;
		bit noisy, s;

		image_count = 0;
		size_now = '0;
		clear_parser();

		//        what      start  byte   image_size  result          value
		add_row(ROW_CFG,  1'b0, 8'h00, 24'd0,      EV_BUS,         15'd0);
		// An empty image ends on its first byte, and the block then ignores bytes.
		add_row(ROW_ONE,  1'b0, 8'h00, 24'd0,      EV_IMAGE_END,   15'd0);
		add_row(ROW_NONE, 1'b0, 8'hFF, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_CFG,  1'b0, 8'h00, 24'd1,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b1, 8'hAB, 24'd0,      EV_IMAGE_END,   15'd0);
		add_row(ROW_CFG,  1'b0, 8'h00, 24'hFFFFFF, EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b1, 8'h00, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h00, 24'd0,      EV_TUNER_RESET, 15'd0);
		add_row(ROW_NONE, 1'b0, 8'hFF, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h00, 24'd0,      EV_CLOCK_RESET, 15'd0);
		add_row(ROW_NONE, 1'b0, 8'h80, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h00, 24'd0,      EV_DELAY,       15'd0);
		add_row(ROW_NONE, 1'b0, 8'hFE, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'hFF, 24'd0,      EV_DELAY,       15'h7EFF);
		// A one-byte chunk holds only its register byte and makes no bus write.
		add_row(ROW_NONE, 1'b0, 8'h00, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b0, 8'h01, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b0, 8'h5A, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_PRED, 1'b0, 8'h00, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_PRED, 1'b0, 8'h02, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_PRED, 1'b0, 8'h12, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_PRED, 1'b0, 8'hFF, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b0, 8'hFF, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h01, 24'd0,      EV_BAD_CODE,    15'd0);
		add_row(ROW_NONE, 1'b1, 8'hFF, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'hFF, 24'd0,      EV_EXIT,        15'd0);
		add_row(ROW_CFG,  1'b0, 8'h00, 24'd10,     EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b1, 8'h00, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h20, 24'd0,      EV_OVERRUN,     15'd0);
		// The size grows mid-image, so the tuner reset no longer ends the image.
		add_row(ROW_CFG,  1'b0, 8'h00, 24'd3,      EV_BUS,         15'd0);
		add_row(ROW_NONE, 1'b1, 8'h00, 24'd0,      EV_BUS,         15'd0);
		add_row(ROW_CFG,  1'b0, 8'h00, 24'd4,      EV_BUS,         15'd0);
		add_row(ROW_ONE,  1'b0, 8'h00, 24'd0,      EV_TUNER_RESET, 15'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].what == ROW_CFG) begin
				drain();
				write_size({8'd0, dir_rows[i].cfg_size});
			end else begin
				offer(dir_rows[i].start, dir_rows[i].data);
				if (dir_rows[i].what == ROW_PRED) begin
					queue_predicted();
				end else if (dir_rows[i].what == ROW_ONE) begin
					typed.kind = dir_rows[i].ev;
					typed.value = dir_rows[i].value;
					typed.wend = 1'b0;
					typed.last = 1'b1;
					events_due.push_back(typed);
				end
			end
		end

		// Random images, each set up while the block is idle.
		random_from = live_items;
		while (live_items - random_from < RANDOM_ITEMS) begin
			build_image(sz, noisy);
			drain();
			if (image_count == 0 || $urandom_range(0, 5) != 0)
				write_size(sz);
			// Hold the receiver off while requests keep coming, so the block backs up.
			if (image_count == 3 || image_count == 15)
				holds_wanted++;
			split = (img_bytes.size() > 4 && $urandom_range(0, 7) == 0) ?
				$urandom_range(1, img_bytes.size() - 1) : 0;
			for (int i = 0; i < img_bytes.size(); i++) begin
				if (split != 0 && i == split) begin
					// Change the size in the middle of an image.
					drain();
					if (sz > 3 && $urandom_range(0, 1) == 0)
						new_sz = sz - $urandom_range(1, 3);
					else
						new_sz = (sz < 32'hFFFFFF) ? sz + 1 : sz - 1;
					write_size(new_sz);
				end
				s = (i == 0) || (noisy && $urandom_range(0, 9) == 0);
				offer(s, img_bytes[i]);
				queue_predicted();
			end
			image_count++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Streamed %0d image bytes (%0d parsed) over %0d random images.", bytes_offered,
			live_items, image_count);
		$display("Checked %0d results across %0d image size settings.", results_checked,
			size_writes);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
